/* src/dts_from_pts_reorder_macros.svh */
// Assertion macros shared by the dts_from_pts_reorder RTL.
`ifndef DTS_FROM_PTS_REORDER_MACROS_SVH
`define DTS_FROM_PTS_REORDER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is asserted
`define DTSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define DTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define DTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/dtsr_pkg.sv */
// Shared types and constants for the DTS reconstruction block.
`timescale 1ns / 1ps
package dtsr_pkg;

	localparam int STAMP_W   = 64;
	localparam int DUR_W     = 32;
	localparam int DELAY_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REORDER_DELAY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION = 1'd1;

	localparam logic [DELAY_W-1:0] DELAY_RESET    = 4'd4;
	localparam logic [DUR_W-1:0]   DURATION_RESET = 32'd1;

	// per-item command from the stamp generator to the sorted store
	typedef struct packed {
		logic step;   // an item is processed this cycle
		logic pop;    // remove the smallest entry after the insert
	} store_ctrl_t;

endpackage

/* src/dts_from_pts_reorder.sv */
// Top level: DTS reconstruction from a PTS-only stream.
// An accepted item is held in the input stage (valid_s1/pts_s1); when it
//   advances, its DTS is registered in the result register (dts_q).
// Throughput: one item per cycle while the output is not back-pressured; the
//   insert/pop into the sorted register array and the synthetic stamp multiply-subtract are both combinational.
// Reset (arst_n low): store empty, item count zero, no first stamp,
//   reorder_delay = 4, frame_duration = 1, both stages empty.
`timescale 1ns / 1ps
`include "dts_from_pts_reorder_macros.svh"
module dts_from_pts_reorder #(
	parameter int MAX_DELAY = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [dtsr_pkg::STAMP_W-1:0]  s_axis_tdata,   // [63:0] pts
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dtsr_pkg::STAMP_W-1:0]  m_axis_tdata,   // [63:0] dts
	// configuration writes
	input  logic                          cfg_wr_en,
	input  logic [dtsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtsr_pkg::CFG_W-1:0]    cfg_data
);
	import dtsr_pkg::*;

	localparam int DEPTH  = MAX_DELAY + 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	// configuration registers
	logic [DELAY_W-1:0] reorder_delay_q;
	logic [DUR_W-1:0]   frame_duration_q;

	// input stage and result register
	logic               valid_s1;
	logic [STAMP_W-1:0] pts_s1;
	logic               out_valid_q;
	logic [STAMP_W-1:0] dts_q;

	logic               advance;
	store_ctrl_t        ctrl;
	logic [STAMP_W-1:0] synth_dts;
	logic [STAMP_W-1:0] min_stamp;
	logic [FILL_W-1:0]  fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reorder_delay_q  <= DELAY_RESET;
			frame_duration_q <= DURATION_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_REORDER_DELAY:  reorder_delay_q  <= cfg_data[DELAY_W-1:0];
				REG_FRAME_DURATION: frame_duration_q <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// the stage-1 item is processed whenever the result register is free
	// or being drained in the same cycle
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pts_s1 <= s_axis_tdata;
		end
	end

	dtsr_stamp_gen #(
		.MAX_DELAY (MAX_DELAY)
	) u_stamp_gen (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.pts            (pts_s1),
		.reorder_delay  (reorder_delay_q),
		.frame_duration (frame_duration_q),
		.ctrl           (ctrl),
		.synth_dts      (synth_dts)
	);

	dtsr_sort_store #(
		.DEPTH (DEPTH)
	) u_sort_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.pts       (pts_s1),
		.min_stamp (min_stamp),
		.fill      (fill)
	);

	// leading items get the synthetic stamp, later ones the popped minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dts_q <= ctrl.pop ? min_stamp : synth_dts;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = dts_q;

	// the store never reaches full depth: synthetic items are bounded by MAX_DELAY
	`DTSR_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill <= FILL_W'(MAX_DELAY), "store overfilled")
	// a pop item leaves the fill unchanged
	`DTSR_ASSERT_NEXT(a_pop_fill, clk, arst_n, advance && ctrl.pop, fill == $past(fill), "pop changed fill")
	// a synthetic item grows the store by one
	`DTSR_ASSERT_NEXT(a_push_fill, clk, arst_n, advance && !ctrl.pop, fill == $past(fill) + FILL_W'(1), "insert lost")
	// an empty result register never blocks the input
	`DTSR_ASSERT_NOW(a_ready_free, clk, arst_n, !out_valid_q, s_axis_tready, "input stalled with free output")

endmodule

/* src/dtsr_sort_store.sv */
// Sorted register array: parallel compare-and-shift insert plus pop of the minimum.
`timescale 1ns / 1ps
module dtsr_sort_store #(
	parameter int DEPTH = 16,
	localparam int FILL_W = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dtsr_pkg::store_ctrl_t               ctrl,
	input  logic [dtsr_pkg::STAMP_W-1:0]        pts,
	output logic [dtsr_pkg::STAMP_W-1:0]        min_stamp,
	output logic [FILL_W-1:0]                   fill
);
	import dtsr_pkg::*;

	logic [STAMP_W-1:0] store_q [DEPTH];
	logic [FILL_W-1:0]  fill_q;

	logic               keep [DEPTH];
	logic [STAMP_W-1:0] ins  [DEPTH];
	logic [STAMP_W-1:0] nxt  [DEPTH];
	logic               full;
	logic [FILL_W-1:0]  fill_next;

	assign full = (fill_q == FILL_W'(DEPTH));

	// entries strictly above pts move up one place; equal ones stay in front
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			keep[i] = (FILL_W'(i) < fill_q) && !($signed(pts) < $signed(store_q[i]));
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (full || keep[i]) begin
				ins[i] = store_q[i];
			end else if (i == 0) begin
				ins[i] = pts;
			end else if (keep[i-1]) begin
				ins[i] = pts;
			end else begin
				ins[i] = store_q[i-1];
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (ctrl.pop && (i < DEPTH - 1)) begin
				nxt[i] = ins[i+1];
			end else begin
				nxt[i] = ins[i];
			end
		end
	end

	always_comb begin
		fill_next = fill_q;
		if (!full) begin
			fill_next = fill_next + FILL_W'(1);
		end
		if (ctrl.pop) begin
			fill_next = fill_next - FILL_W'(1);
		end
	end

	assign min_stamp = ins[0];
	assign fill      = fill_q;

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			for (int i = 0; i < DEPTH; i++) begin
				store_q[i] <= nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.step) begin
			fill_q <= fill_next;
		end
	end

endmodule

/* src/dtsr_stamp_gen.sv */
// Item counter, first stamp and synthetic DTS for the leading items.
`timescale 1ns / 1ps
module dtsr_stamp_gen #(
	parameter int MAX_DELAY = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [dtsr_pkg::STAMP_W-1:0]  pts,
	input  logic [dtsr_pkg::DELAY_W-1:0]  reorder_delay,
	input  logic [dtsr_pkg::DUR_W-1:0]    frame_duration,
	output dtsr_pkg::store_ctrl_t         ctrl,
	output logic [dtsr_pkg::STAMP_W-1:0]  synth_dts
);
	import dtsr_pkg::*;

	localparam int DLY_W  = $clog2(MAX_DELAY + 1);
	localparam int CMP_W  = (DLY_W > DELAY_W) ? DLY_W : DELAY_W;
	localparam int PROD_W = DLY_W + DUR_W;

	logic [DLY_W-1:0]   items_q;
	logic               first_seen_q;
	logic [STAMP_W-1:0] first_stamp_q;

	logic [DLY_W-1:0]   delay_c;
	logic [DLY_W-1:0]   gap;
	logic [PROD_W-1:0]  prod;
	logic [STAMP_W-1:0] base;
	logic               synth;

	// clamp the programmed delay to MAX_DELAY
	always_comb begin
		if (CMP_W'(reorder_delay) > CMP_W'(MAX_DELAY)) begin
			delay_c = DLY_W'(MAX_DELAY);
		end else begin
			delay_c = DLY_W'(reorder_delay);
		end
	end

	assign synth = (items_q < delay_c);
	assign gap   = delay_c - items_q;
	assign prod  = PROD_W'(gap) * PROD_W'(frame_duration);
	assign base  = first_seen_q ? first_stamp_q : pts;

	assign synth_dts = base - STAMP_W'(prod);
	assign ctrl.step = step;
	assign ctrl.pop  = !synth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q      <= '0;
			first_seen_q <= 1'b0;
		end else if (step) begin
			if (items_q != DLY_W'(MAX_DELAY)) begin
				items_q <= items_q + DLY_W'(1);
			end
			first_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !first_seen_q) begin
			first_stamp_q <= pts;
		end
	end

endmodule
